### design/pfde_pkg.sv
// Shared types, constants and grid helper functions for the Playfair digraph encryptor.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package pfde_pkg;

	localparam int LETTER_W     = 5;
	localparam int CMD_W        = 2;
	localparam int RC_W         = 3;
	localparam int GRID_SIDE    = 5;
	localparam int GRID_CELLS   = 25;
	localparam int LETTER_COUNT = 26;
	localparam int QUEUE_DEPTH  = 2;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [LETTER_W-1:0] cell_t;
	typedef logic [RC_W-1:0]     rc_t;

	localparam letter_t LETTER_I     = 5'd8;
	localparam letter_t LETTER_J     = 5'd9;
	localparam letter_t LETTER_Z     = 5'd25;
	localparam letter_t FILLER_RESET = 5'd23;

	// Register index of the filler letter register.
	localparam logic REG_FILLER = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_KEY  = 2'd0,
		CMD_SEAL = 2'd1,
		CMD_MSG  = 2'd2,
		CMD_END  = 2'd3
	} cmd_t;

	// One digraph waiting to be enciphered.
	typedef struct packed {
		letter_t first;
		letter_t second;
		logic    last;
	} pair_job_t;

	// Grid append request from the front to the grid memories.
	typedef struct packed {
		logic    en;
		cell_t   pos;
		letter_t letter;
	} grid_wr_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef struct packed {
		logic busy;
	} back_status_t;

	function automatic letter_t fold(input letter_t l);
		return (l == LETTER_J) ? LETTER_I : l;
	endfunction

	// Row of a grid position; positions beyond the grid read as the top left cell.
	function automatic rc_t row_of(input cell_t p);
		rc_t r;
		if (p < cell_t'(5)) begin
			r = rc_t'(0);
		end else if (p < cell_t'(10)) begin
			r = rc_t'(1);
		end else if (p < cell_t'(15)) begin
			r = rc_t'(2);
		end else if (p < cell_t'(20)) begin
			r = rc_t'(3);
		end else if (p < cell_t'(GRID_CELLS)) begin
			r = rc_t'(4);
		end else begin
			r = rc_t'(0);
		end
		return r;
	endfunction

	function automatic cell_t cell_index(input rc_t r, input rc_t c);
		return cell_t'({r, 2'b00}) + cell_t'(r) + cell_t'(c);
	endfunction

	function automatic rc_t col_of(input cell_t p);
		cell_t t;
		t = p - cell_index(row_of(p), rc_t'(0));
		return (p < cell_t'(GRID_CELLS)) ? t[RC_W-1:0] : rc_t'(0);
	endfunction

	function automatic rc_t wrap_inc(input rc_t v);
		return (v == rc_t'(GRID_SIDE - 1)) ? rc_t'(0) : v + rc_t'(1);
	endfunction

endpackage

### design/pfde_if.sv
// Valid/ready channel interfaces for the item input and the cipher letter output.
// Depends on pfde_pkg for the field widths.
interface pfde_in_if;
	logic                          valid;
	logic                          ready;
	logic [pfde_pkg::CMD_W-1:0]    cmd;
	logic [pfde_pkg::LETTER_W-1:0] letter;

	modport source (output valid, output cmd, output letter, input ready);
	modport sink (input valid, input cmd, input letter, output ready);
endinterface

interface pfde_out_if;
	logic                          valid;
	logic                          ready;
	logic [pfde_pkg::LETTER_W-1:0] cipher_letter;
	logic                          last_of_message;

	modport source (output valid, output cipher_letter, output last_of_message, input ready);
	modport sink (input valid, input cipher_letter, input last_of_message, output ready);
endinterface

### design/pfde_front.sv
// Front end: accepts items, builds the key grid and forms digraphs with repeat splitting.
// Depends on pfde_pkg and pfde_in_if; feeds pfde_queue and writes the grid in pfde_back.
module pfde_front (
	input  logic                    clk,
	input  logic                    arst_n,
	pfde_in_if.sink                 items,
	input  pfde_pkg::letter_t       filler,
	input  pfde_pkg::queue_status_t q_status,
	input  pfde_pkg::back_status_t  b_status,
	output logic                    push,
	output pfde_pkg::pair_job_t     job,
	output pfde_pkg::grid_wr_t      wr
);

	typedef enum logic [1:0] {
		F_RUN  = 2'b01,
		F_SEAL = 2'b10
	} front_state_t;

	front_state_t                  state_q, state_d;
	logic [pfde_pkg::LETTER_COUNT-1:0] used_q;
	pfde_pkg::cell_t               fill_q;
	pfde_pkg::letter_t             seal_idx_q;
	pfde_pkg::letter_t             held_q, held_d;
	pfde_pkg::letter_t             pf_q, pf_d;
	logic                          hv_q, hv_d;
	logic                          pfv_q, pfv_d;

	logic                          accept;
	logic                          letter_ok;
	logic                          place_req;
	logic                          place_go;
	pfde_pkg::letter_t             place_letter;

	// Grid edits wait until every queued digraph has been enciphered.
	always_comb begin
		items.ready = 1'b0;
		unique case (state_q)
			F_RUN: begin
				case (items.cmd) inside
					pfde_pkg::CMD_KEY, pfde_pkg::CMD_SEAL: begin
						items.ready = q_status.empty && !b_status.busy;
					end
					default: begin
						items.ready = !q_status.full;
					end
				endcase
			end
			F_SEAL: items.ready = 1'b0;
			default: items.ready = 1'b0;
		endcase
	end

	assign accept    = items.valid && items.ready;
	assign letter_ok = items.letter < pfde_pkg::letter_t'(pfde_pkg::LETTER_COUNT);

	always_comb begin
		if (state_q == F_SEAL) begin
			place_letter = seal_idx_q;
			place_req    = seal_idx_q != pfde_pkg::LETTER_J;
		end else begin
			place_letter = pfde_pkg::fold(items.letter);
			place_req    = accept && (items.cmd == pfde_pkg::CMD_KEY) && letter_ok;
		end
		place_go = place_req && (fill_q < pfde_pkg::cell_t'(pfde_pkg::GRID_CELLS))
			&& !used_q[place_letter];
	end

	assign wr.en     = place_go;
	assign wr.pos    = fill_q;
	assign wr.letter = place_letter;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_RUN: begin
				if (accept && (items.cmd == pfde_pkg::CMD_SEAL)) begin
					state_d = F_SEAL;
				end
			end
			F_SEAL: begin
				if (seal_idx_q == pfde_pkg::LETTER_Z) begin
					state_d = F_RUN;
				end
			end
			default: state_d = F_RUN;
		endcase
	end

	// Digraph formation: the held letter is released when the next one arrives, and
	// a repeat of the held letter puts the filler between the two.
	always_comb begin
		push   = 1'b0;
		job    = '{first: pf_q, second: held_q, last: 1'b0};
		held_d = held_q;
		hv_d   = hv_q;
		pf_d   = pf_q;
		pfv_d  = pfv_q;
		if (accept && (items.cmd == pfde_pkg::CMD_MSG) && letter_ok) begin
			held_d = items.letter;
			hv_d   = 1'b1;
			if (hv_q) begin
				if (!pfv_q) begin
					if (held_q == items.letter) begin
						push  = 1'b1;
						job   = '{first: held_q, second: filler, last: 1'b0};
						pfv_d = 1'b0;
					end else begin
						pf_d  = held_q;
						pfv_d = 1'b1;
					end
				end else begin
					push = 1'b1;
					job  = '{first: pf_q, second: held_q, last: 1'b0};
					if (held_q == items.letter) begin
						pf_d  = filler;
						pfv_d = 1'b1;
					end else begin
						pfv_d = 1'b0;
					end
				end
			end
		end else if (accept && (items.cmd == pfde_pkg::CMD_END)) begin
			hv_d  = 1'b0;
			pfv_d = 1'b0;
			if (hv_q && !pfv_q) begin
				push = 1'b1;
				job  = '{first: held_q, second: filler, last: 1'b1};
			end else if (hv_q) begin
				push = 1'b1;
				job  = '{first: pf_q, second: held_q, last: 1'b1};
			end else if (pfv_q) begin
				push = 1'b1;
				job  = '{first: pf_q, second: filler, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_RUN;
			used_q     <= '0;
			fill_q     <= '0;
			seal_idx_q <= '0;
			hv_q       <= 1'b0;
			pfv_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			hv_q    <= hv_d;
			pfv_q   <= pfv_d;
			if (place_go) begin
				used_q[place_letter] <= 1'b1;
				fill_q               <= fill_q + pfde_pkg::cell_t'(1);
			end
			if (state_q == F_SEAL) begin
				seal_idx_q <= seal_idx_q + pfde_pkg::letter_t'(1);
			end else begin
				seal_idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
		pf_q   <= pf_d;
	end

	a_fill_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(fill_q))
		else $error("grid fill count disagrees with the used letter set");

	a_no_j_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		!used_q[pfde_pkg::LETTER_J])
		else $error("letter J was placed in the grid");

	a_seal_fills_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_SEAL) && (seal_idx_q == pfde_pkg::LETTER_Z)
		|=> fill_q == pfde_pkg::cell_t'(pfde_pkg::GRID_CELLS))
		else $error("grid not full after the seal walk");

endmodule

### design/pfde_queue.sv
// Short FIFO of digraph jobs between the front end and the cipher back end.
// Depends on pfde_pkg for the job type.
module pfde_queue #(
	parameter int DEPTH = pfde_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  pfde_pkg::pair_job_t     push_job,
	input  logic                    pop,
	output pfde_pkg::pair_job_t     head,
	output pfde_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfde_pkg::pair_job_t slot_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head         = slot_q[rd_ptr_q];
	assign status.empty = count_q == '0;
	assign status.full  = count_q == CNT_W'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### design/pfde_back.sv
// Back end: holds the key grid memories, looks up each digraph and emits two cipher letters.
// Depends on pfde_pkg and pfde_out_if; takes jobs from pfde_queue and grid writes from pfde_front.
module pfde_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pfde_pkg::grid_wr_t      wr,
	input  pfde_pkg::queue_status_t q_status,
	input  pfde_pkg::pair_job_t     head,
	output logic                    pop,
	output pfde_pkg::back_status_t  status,
	pfde_out_if.source              results
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_POS  = 4'b0010,
		B_OUT0 = 4'b0100,
		B_OUT1 = 4'b1000
	} back_state_t;

	back_state_t       state_q, state_d;

	pfde_pkg::letter_t grid_mem [pfde_pkg::GRID_CELLS];
	pfde_pkg::cell_t   pos_mem  [pfde_pkg::LETTER_COUNT];

	pfde_pkg::cell_t   pos_a_q, pos_b_q;
	pfde_pkg::letter_t grid_a_q, grid_b_q;
	logic              last_q;

	pfde_pkg::rc_t     r1, c1, r2, c2;
	pfde_pkg::cell_t   idx1, idx2;

	assign pop         = (state_q == B_IDLE) && !q_status.empty;
	assign status.busy = state_q != B_IDLE;

	// Digraph rule on the two looked-up positions.
	always_comb begin
		r1 = pfde_pkg::row_of(pos_a_q);
		c1 = pfde_pkg::col_of(pos_a_q);
		r2 = pfde_pkg::row_of(pos_b_q);
		c2 = pfde_pkg::col_of(pos_b_q);
		if (r1 == r2) begin
			idx1 = pfde_pkg::cell_index(r1, pfde_pkg::wrap_inc(c1));
			idx2 = pfde_pkg::cell_index(r2, pfde_pkg::wrap_inc(c2));
		end else if (c1 == c2) begin
			idx1 = pfde_pkg::cell_index(pfde_pkg::wrap_inc(r1), c1);
			idx2 = pfde_pkg::cell_index(pfde_pkg::wrap_inc(r2), c2);
		end else begin
			idx1 = pfde_pkg::cell_index(r1, c2);
			idx2 = pfde_pkg::cell_index(r2, c1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			grid_mem[wr.pos] <= wr.letter;
			pos_mem[wr.letter] <= wr.pos;
		end
		if (pop) begin
			pos_a_q <= pos_mem[pfde_pkg::fold(head.first)];
			pos_b_q <= pos_mem[pfde_pkg::fold(head.second)];
			last_q  <= head.last;
		end
		if (state_q == B_POS) begin
			grid_a_q <= grid_mem[idx1];
			grid_b_q <= grid_mem[idx2];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					state_d = B_POS;
				end
			end
			B_POS: state_d = B_OUT0;
			B_OUT0: begin
				if (results.ready) begin
					state_d = B_OUT1;
				end
			end
			B_OUT1: begin
				if (results.ready) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign results.valid           = (state_q == B_OUT0) || (state_q == B_OUT1);
	assign results.cipher_letter   = (state_q == B_OUT1) ? grid_b_q : grid_a_q;
	assign results.last_of_message = (state_q == B_OUT1) && last_q;

	a_write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == B_IDLE)
		else $error("grid written while a digraph is in flight");

	a_pop_starts_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == B_POS)
		else $error("popped job not looked up");

	a_lookup_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_POS |=> state_q == B_OUT0)
		else $error("lookup not followed by the first cipher letter");

endmodule

### design/playfair_digraph_encrypt.sv
// Top level of the Playfair digraph encryptor: filler register, front end, job queue, back end.
// Depends on pfde_pkg, pfde_if, pfde_front, pfde_queue and pfde_back.
//
// Usage. Items arrive on the items channel (cmd, letter) and cipher letters leave on the
// results channel (cipher_letter, last_of_message); each channel moves one transaction at a
// clock edge where valid and ready are both high. Key letters build the 5x5 grid, a seal
// command completes it, message letters are enciphered in digraphs and an end command
// flushes the message, flagging its final cipher letter.
// A key letter or seal is taken only once every queued digraph has left the back end; a seal
// then walks the alphabet to complete the grid, during which no item is taken. Message and
// end items are taken while the job queue has room.
// A digraph's first cipher letter is valid once the transaction that completes it has passed
// through the queue slot, the position registers and the cell registers; its second follows in
// the cycle after the first is taken. The back end handles one digraph at a time and pops no
// new job until both cipher letters of the last have been taken (lookup of both positions,
// lookup of both cells, then the two cipher letters in turn).
// When the receiver stalls, the current cipher letter holds; the queue absorbs up to
// QUEUE_DEPTH further digraphs before the items channel stalls too.
// Reset empties the grid, the pending letters and the queue, and sets the filler to X.
// The filler register sits at byte address 0 of the APB-style port; it is written at the
// access phase and always reads back its stored value.
module playfair_digraph_encrypt #(
	parameter int QUEUE_DEPTH = pfde_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	pfde_in_if.sink     items,
	pfde_out_if.source  results
);

	pfde_pkg::letter_t       filler_q;
	pfde_pkg::letter_t       filler_sat;
	logic                    cfg_write;

	logic                    push;
	logic                    pop;
	pfde_pkg::pair_job_t     push_job;
	pfde_pkg::pair_job_t     head;
	pfde_pkg::grid_wr_t      grid_wr;
	pfde_pkg::queue_status_t q_status;
	pfde_pkg::back_status_t  b_status;

	// The port never inserts wait states.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filler_q <= pfde_pkg::FILLER_RESET;
		end else if (cfg_write && (paddr[2] == pfde_pkg::REG_FILLER)) begin
			filler_q <= pwdata[pfde_pkg::LETTER_W-1:0];
		end
	end

	assign prdata = (paddr[2] == pfde_pkg::REG_FILLER)
		? {{(32 - pfde_pkg::LETTER_W){1'b0}}, filler_q} : 32'd0;

	// Codes beyond Z in the register are used as Z.
	assign filler_sat = (filler_q > pfde_pkg::LETTER_Z) ? pfde_pkg::LETTER_Z : filler_q;

	pfde_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.filler   (filler_sat),
		.q_status (q_status),
		.b_status (b_status),
		.push     (push),
		.job      (push_job),
		.wr       (grid_wr)
	);

	pfde_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	pfde_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (grid_wr),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.status   (b_status),
		.results  (results)
	);

endmodule
